### rtl/byte_matrix_flip_transpose_defines.svh
// Assertion helpers for the checker file.
`ifndef BYTE_MATRIX_FLIP_TRANSPOSE_DEFINES_SVH
`define BYTE_MATRIX_FLIP_TRANSPOSE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BMFT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BMFT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/bmft_pkg.sv
`default_nettype none

package bmft_pkg;

    localparam int OPCODE_W  = 3;
    localparam int INDEX_W   = 6;
    localparam int DATA_W    = 8;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_W-1:0] COUNT_RESET = 7'd64;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_WRITE      = 3'd0,
        OP_READ       = 3'd1,
        OP_FLIP_VERT  = 3'd2,
        OP_FLIP_HORIZ = 3'd3,
        OP_TRANSPOSE  = 3'd4,
        OP_SWAP_ROWS  = 3'd5,
        OP_SWAP_COLS  = 3'd6
    } op_t;

    // Status from the exchange walker to the top level.
    typedef struct packed {
        logic busy;  // walk in progress
        logic swap;  // exchange issued this cycle on addr_a / addr_b
    } walk_stat_t;

endpackage

`default_nettype wire

### rtl/bmft_walk.sv
`default_nettype none

// Walks the (outer, inner) index space of a whole-matrix operation and
// issues cell exchanges, with an idle phase (phase_reg) after each one.
module bmft_walk #(
    parameter int MAX_DIM = 64
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire bmft_pkg::op_t                      op,
    input  wire logic [$clog2(MAX_DIM+1)-1:0]       nr,
    input  wire logic [$clog2(MAX_DIM+1)-1:0]       nc,
    input  wire logic [$clog2(MAX_DIM)-1:0]         first_idx,
    input  wire logic [$clog2(MAX_DIM)-1:0]         second_idx,
    output bmft_pkg::walk_stat_t                    stat,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]      addr_a,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]      addr_b
);
    import bmft_pkg::*;

    localparam int IW = $clog2(MAX_DIM);
    localparam int CW = $clog2(MAX_DIM + 1);
    localparam int AW = $clog2(MAX_DIM * MAX_DIM);

    logic          busy_reg;
    logic          phase_reg;
    op_t           kind_reg;
    logic [CW-1:0] nr_reg;
    logic [CW-1:0] nc_reg;
    logic [IW-1:0] fa_reg;
    logic [IW-1:0] fb_reg;
    logic [CW-1:0] o_reg;
    logic [CW-1:0] n_reg;

    logic [CW-1:0] o_lim;
    logic [CW-1:0] n_lim;
    logic [CW-1:0] row_a;
    logic [CW-1:0] col_a;
    logic [CW-1:0] row_b;
    logic [CW-1:0] col_b;
    logic          active;
    logic          in_outer;
    logic          in_inner;

    always_comb
    begin
        o_lim = '0;
        n_lim = '0;
        row_a = o_reg;
        col_a = n_reg;
        row_b = o_reg;
        col_b = n_reg;
        unique case (kind_reg)
            OP_FLIP_VERT:
            begin
                o_lim = nr_reg;
                n_lim = nc_reg >> 1;
                col_b = nc_reg - CW'(1) - n_reg;
            end
            OP_FLIP_HORIZ:
            begin
                o_lim = nr_reg >> 1;
                n_lim = nc_reg;
                row_b = nr_reg - CW'(1) - o_reg;
            end
            OP_TRANSPOSE:
            begin
                o_lim = nr_reg;
                n_lim = nc_reg;
                row_b = n_reg;
                col_b = o_reg;
            end
            OP_SWAP_ROWS:
            begin
                o_lim = CW'(1);
                n_lim = nc_reg;
                row_a = CW'(fa_reg);
                row_b = CW'(fb_reg);
            end
            OP_SWAP_COLS:
            begin
                o_lim = CW'(1);
                n_lim = nr_reg;
                row_a = n_reg;
                col_a = CW'(fa_reg);
                row_b = n_reg;
                col_b = CW'(fb_reg);
            end
            default:
            begin
                o_lim = '0;
            end
        endcase
    end

    assign active   = busy_reg && !phase_reg;
    assign in_outer = o_reg < o_lim;
    assign in_inner = n_reg < n_lim;

    assign stat.busy = busy_reg;
    assign stat.swap = active && in_outer && in_inner;

    // row * MAX_DIM + col, constant multiply
    assign addr_a = AW'(row_a) * AW'(MAX_DIM) + AW'(col_a);
    assign addr_b = AW'(row_b) * AW'(MAX_DIM) + AW'(col_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            phase_reg <= 1'b0;
        end
        else if (active)
        begin
            if (!in_outer)
            begin
                busy_reg <= 1'b0;
            end
            else if (in_inner)
            begin
                phase_reg <= 1'b1;
            end
        end
        else
        begin
            phase_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            kind_reg <= op;
            nr_reg   <= nr;
            nc_reg   <= nc;
            fa_reg   <= first_idx;
            fb_reg   <= second_idx;
            o_reg    <= '0;
            n_reg    <= (op == OP_TRANSPOSE) ? CW'(1) : '0;
        end
        else if (active && in_outer)
        begin
            if (in_inner)
            begin
                n_reg <= n_reg + CW'(1);
            end
            else
            begin
                // next row; transpose starts right of the diagonal
                o_reg <= o_reg + CW'(1);
                n_reg <= (kind_reg == OP_TRANSPOSE) ? o_reg + CW'(2) : '0;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/byte_matrix_flip_transpose.sv
// Channel | Direction | Handshake           | Payload
// --------+-----------+---------------------+------------------------------------------
// in      | input     | in_valid / in_stall | opcode row col cell_value first_index
//         |           |                     | second_index
// out     | output    | out_valid/out_stall | read_value error
// cfg     | input     | cfg_write           | cfg_index cfg_data
//
// One beat in, one beat out. Write and refused items go through S_FINISH to the
// output register, a read through S_READ and then S_FINISH. Whole-matrix items
// go through the single cell memory one exchange at a time in S_RUN, then S_FINISH.
// Reset (rst_n, async) clears control and sets both counts to 64; cell
// contents are undefined until written. A stalled result sits in the output
// register; the next beat is taken once the block is back in idle.
`default_nettype none

module byte_matrix_flip_transpose #(
    parameter int MAX_DIM = 64
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // input channel
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [bmft_pkg::OPCODE_W-1:0]     opcode,
    input  wire logic [bmft_pkg::INDEX_W-1:0]      row,
    input  wire logic [bmft_pkg::INDEX_W-1:0]      col,
    input  wire logic [bmft_pkg::DATA_W-1:0]       cell_value,
    input  wire logic [bmft_pkg::INDEX_W-1:0]      first_index,
    input  wire logic [bmft_pkg::INDEX_W-1:0]      second_index,
    // output channel
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [bmft_pkg::DATA_W-1:0]            read_value,
    output logic                                   error,
    // configuration
    input  wire logic                              cfg_write,
    input  wire logic [bmft_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bmft_pkg::CFG_W-1:0]        cfg_data
);
    import bmft_pkg::*;

    localparam int IW    = $clog2(MAX_DIM);
    localparam int CW    = $clog2(MAX_DIM + 1);
    localparam int AW    = $clog2(MAX_DIM * MAX_DIM);
    localparam int DEPTH = MAX_DIM * MAX_DIM;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_RUN,
        S_FINISH
    } state_t;

    // ---------------------------------------------------------------
    // Configuration: counts keep the written bits, use saturates.
    // ---------------------------------------------------------------
    logic [CFG_W-1:0] row_count_reg;
    logic [CFG_W-1:0] column_count_reg;
    logic [CW-1:0]    nr;
    logic [CW-1:0]    nc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= COUNT_RESET;
            column_count_reg <= COUNT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ROW_COUNT:    row_count_reg    <= cfg_data;
                REG_COLUMN_COUNT: column_count_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign nr = (32'(row_count_reg) > MAX_DIM) ? CW'(MAX_DIM) : CW'(row_count_reg);
    assign nc = (32'(column_count_reg) > MAX_DIM) ? CW'(MAX_DIM) : CW'(column_count_reg);

    // ---------------------------------------------------------------
    // Decode of the incoming beat
    // ---------------------------------------------------------------
    state_t state_reg;
    op_t    op_in;
    logic   in_acc;
    logic   cell_ok;
    logic   rows_ok;
    logic   cols_ok;
    logic   acc_err;
    logic   walk_go;
    logic [AW-1:0] cell_addr;

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign op_in    = op_t'(opcode);

    assign cell_ok = (32'(row) < 32'(nr)) && (32'(col) < 32'(nc));
    assign rows_ok = (32'(first_index) < 32'(nr)) && (32'(second_index) < 32'(nr));
    assign cols_ok = (32'(first_index) < 32'(nc)) && (32'(second_index) < 32'(nc));

    // address is only used when in range
    assign cell_addr = AW'(row) * AW'(MAX_DIM) + AW'(col);

    always_comb
    begin
        acc_err = 1'b0;
        walk_go = 1'b0;
        unique case (op_in)
            OP_WRITE, OP_READ:
            begin
                acc_err = !cell_ok;
            end
            OP_FLIP_VERT, OP_FLIP_HORIZ:
            begin
                walk_go = 1'b1;
            end
            OP_TRANSPOSE:
            begin
                // 1x1 and 0x0 are square and walk nothing
                acc_err = (nr != nc);
                walk_go = (nr == nc);
            end
            OP_SWAP_ROWS:
            begin
                acc_err = !rows_ok;
                walk_go = rows_ok && (first_index != second_index);
            end
            OP_SWAP_COLS:
            begin
                acc_err = !cols_ok;
                walk_go = cols_ok && (first_index != second_index);
            end
            default:
            begin
                acc_err = 1'b1;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Exchange walker
    // ---------------------------------------------------------------
    walk_stat_t    walk_stat;
    logic [AW-1:0] walk_addr_a;
    logic [AW-1:0] walk_addr_b;

    bmft_walk #(
        .MAX_DIM (MAX_DIM)
    ) u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (in_acc && walk_go),
        .op         (op_in),
        .nr         (nr),
        .nc         (nc),
        .first_idx  (IW'(first_index)),
        .second_idx (IW'(second_index)),
        .stat       (walk_stat),
        .addr_a     (walk_addr_a),
        .addr_b     (walk_addr_b)
    );

    // ---------------------------------------------------------------
    // Cell memory: one write port, two registered read ports.
    // Exchange order: read a and b; write a <= old b (pend1); then write
    // b <= old a (pend2). The walker idles a phase after each exchange and no
    // cell is touched twice in one item, so no forwarding is needed.
    // ---------------------------------------------------------------
    logic [DATA_W-1:0] cell_mem [DEPTH];
    logic [DATA_W-1:0] rdata_a_reg;
    logic [DATA_W-1:0] rdata_b_reg;
    logic [AW-1:0]     raddr_a;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;

    logic              pend1_reg;
    logic              pend2_reg;
    logic [AW-1:0]     sw_a_reg;
    logic [AW-1:0]     sw_b_reg;
    logic [AW-1:0]     hold_addr_reg;
    logic [DATA_W-1:0] hold_val_reg;

    assign raddr_a = (state_reg == S_IDLE) ? cell_addr : walk_addr_a;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cell_addr;
        mem_wdata = cell_value;
        priority if (pend1_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = sw_a_reg;
            mem_wdata = rdata_b_reg;
        end
        else if (pend2_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = hold_addr_reg;
            mem_wdata = hold_val_reg;
        end
        else if (in_acc && (op_in == OP_WRITE) && cell_ok)
        begin
            mem_we = 1'b1;
        end
        else
        begin
            mem_we = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
        rdata_a_reg <= cell_mem[raddr_a];
        rdata_b_reg <= cell_mem[walk_addr_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend1_reg <= 1'b0;
            pend2_reg <= 1'b0;
        end
        else
        begin
            pend1_reg <= walk_stat.swap;
            pend2_reg <= pend1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sw_a_reg      <= walk_addr_a;
        sw_b_reg      <= walk_addr_b;
        hold_addr_reg <= sw_b_reg;
        hold_val_reg  <= rdata_a_reg;
    end

    // ---------------------------------------------------------------
    // Control and output register
    // ---------------------------------------------------------------
    logic [DATA_W-1:0] res_val_reg;
    logic              res_err_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] read_value_reg;
    logic              error_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            res_val_reg    <= '0;
            res_err_reg    <= 1'b0;
            read_value_reg <= '0;
            error_reg      <= 1'b0;
        end
        else
        begin
            // S_FINISH reloads the output register on its own
            if (out_valid_reg && !out_stall && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        res_val_reg <= '0;
                        res_err_reg <= acc_err;
                        if (walk_go)
                        begin
                            state_reg <= S_RUN;
                        end
                        else if ((op_in == OP_READ) && cell_ok)
                        begin
                            state_reg <= S_READ;
                        end
                        else
                        begin
                            state_reg <= S_FINISH;
                        end
                    end
                end
                S_READ:
                begin
                    res_val_reg <= rdata_a_reg;
                    state_reg   <= S_FINISH;
                end
                S_RUN:
                begin
                    // walk done and both write-backs landed
                    if (!walk_stat.busy && !pend1_reg && !pend2_reg)
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg  <= 1'b1;
                        read_value_reg <= res_val_reg;
                        error_reg      <= res_err_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign error      = error_reg;

endmodule

`default_nettype wire

### rtl/bmft_checker.sv
`default_nettype none

`include "byte_matrix_flip_transpose_defines.svh"

module bmft_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_stall,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic [bmft_pkg::DATA_W-1:0]   read_value,
    input wire logic                          error
);

    `BMFT_ASSERT_NEXT(a_out_valid_holds, clk, rst_n, out_valid && out_stall, out_valid, "out beat dropped while stalled")
    `BMFT_ASSERT_NEXT(a_out_payload_holds, clk, rst_n, out_valid && out_stall, $stable(read_value) && $stable(error), "out payload changed while stalled")
    `BMFT_ASSERT_SAME(a_error_zero_value, clk, rst_n, out_valid && error, read_value == '0, "refused item carries a nonzero byte")
    `BMFT_ASSERT_NEXT(a_one_item_at_a_time, clk, rst_n, in_valid && !in_stall, in_stall, "second beat taken before result")
    `BMFT_ASSERT_SAME(a_result_after_work, clk, rst_n, $rose(out_valid), $past(in_stall), "result appeared with no item in flight")

endmodule

bind byte_matrix_flip_transpose bmft_checker u_bmft_checker (.*);

`default_nettype wire

### sim/tb_byte_matrix_flip_transpose.sv
`default_nettype none

module tb_byte_matrix_flip_transpose;

    import bmft_pkg::*;

    localparam int DIM = 64;

    // opcode value with no operation behind it
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;

    // long receiver hold-off, in cycles
    localparam int HOLD_CYCLES = 300;

    // One input beat, field for field as on the ports.
    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [INDEX_W-1:0]  row;
        logic [INDEX_W-1:0]  col;
        logic [DATA_W-1:0]   cell_value;
        logic [INDEX_W-1:0]  first_index;
        logic [INDEX_W-1:0]  second_index;
    } beat_t;

    typedef struct {
        logic [DATA_W-1:0] read_value;
        logic              error;
    } result_t;

    // Mirror of the matrix: byte contents, plus a flag per cell telling whether
    // its content came from a write. The flag travels with the byte on every
    // exchange, so stimulus can steer clear of reads of never-written cells.
    class matrix_scoreboard;
        logic [DATA_W-1:0] cells [DIM*DIM];
        bit                written [DIM*DIM];
        logic [CFG_W-1:0]  row_reg;
        logic [CFG_W-1:0]  col_reg;
        result_t           expected_q [$];
        int                errors;

        function new();
            foreach (cells[k])
            begin
                cells[k]   = '0;
                written[k] = 1'b0;
            end
            row_reg = COUNT_RESET;
            col_reg = COUNT_RESET;
            errors  = 0;
        endfunction

        function void set_count(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            if (idx == REG_ROW_COUNT)
                row_reg = value;
            else
                col_reg = value;
        endfunction

        // counts above the matrix limit saturate; the register keeps its bits
        function int active_rows();
            return (row_reg > DIM) ? DIM : int'(row_reg);
        endfunction

        function int active_cols();
            return (col_reg > DIM) ? DIM : int'(col_reg);
        endfunction

        function int cell_at(int r, int c);
            return r * DIM + c;
        endfunction

        function bit is_written(int r, int c);
            return written[cell_at(r, c)];
        endfunction

        function void swap_cells(int r1, int c1, int r2, int c2);
            logic [DATA_W-1:0] t;
            bit                w;
            int                a;
            int                b;
            a = cell_at(r1, c1);
            b = cell_at(r2, c2);
            t = cells[a];
            w = written[a];
            cells[a]   = cells[b];
            written[a] = written[b];
            cells[b]   = t;
            written[b] = w;
        endfunction

        // Apply one accepted beat to the mirror and queue the result it gives.
        function void note_input(beat_t b);
            result_t res;
            int      nr;
            int      nc;
            int      i;
            int      j;
            int      fa;
            int      sa;
            nr = active_rows();
            nc = active_cols();
            fa = int'(b.first_index);
            sa = int'(b.second_index);
            res.read_value = '0;
            res.error      = 1'b0;
            case (b.opcode)
                OP_WRITE, OP_READ:
                begin
                    if (int'(b.row) >= nr || int'(b.col) >= nc)
                        res.error = 1'b1;
                    else if (b.opcode == OP_WRITE)
                    begin
                        cells[cell_at(b.row, b.col)]   = b.cell_value;
                        written[cell_at(b.row, b.col)] = 1'b1;
                    end
                    else
                        res.read_value = cells[cell_at(b.row, b.col)];
                end
                OP_FLIP_VERT:
                begin
                    for (j = 0; j < nc / 2; j++)
                        for (i = 0; i < nr; i++)
                            swap_cells(i, j, i, nc - 1 - j);
                end
                OP_FLIP_HORIZ:
                begin
                    for (i = 0; i < nr / 2; i++)
                        for (j = 0; j < nc; j++)
                            swap_cells(i, j, nr - 1 - i, j);
                end
                OP_TRANSPOSE:
                begin
                    if (nr != nc)
                        res.error = 1'b1;
                    else
                        for (i = 0; i < nr; i++)
                            for (j = i + 1; j < nc; j++)
                                swap_cells(i, j, j, i);
                end
                OP_SWAP_ROWS:
                begin
                    if (fa >= nr || sa >= nr)
                        res.error = 1'b1;
                    else if (fa != sa)
                        for (j = 0; j < nc; j++)
                            swap_cells(fa, j, sa, j);
                end
                OP_SWAP_COLS:
                begin
                    if (fa >= nc || sa >= nc)
                        res.error = 1'b1;
                    else if (fa != sa)
                        for (i = 0; i < nr; i++)
                            swap_cells(i, fa, i, sa);
                end
                default:
                    res.error = 1'b1;
            endcase
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [DATA_W-1:0] rv, logic er);
            result_t want;
            if (expected_q.size() == 0)
            begin
                $error("result beat with nothing expected: read_value=%0h error=%0b", rv, er);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (rv !== want.read_value)
            begin
                $error("read_value: expected %0h, got %0h", want.read_value, rv);
                errors++;
            end
            if (er !== want.error)
            begin
                $error("error: expected %0b, got %0b", want.error, er);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // ---------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ---------------------------------------------------------------------
    logic                 clk;
    logic                 rst_n        = 1'b0;
    logic                 in_valid     = 1'b0;
    logic                 in_stall;
    logic [OPCODE_W-1:0]  opcode       = '0;
    logic [INDEX_W-1:0]   row          = '0;
    logic [INDEX_W-1:0]   col          = '0;
    logic [DATA_W-1:0]    cell_value   = '0;
    logic [INDEX_W-1:0]   first_index  = '0;
    logic [INDEX_W-1:0]   second_index = '0;
    logic                 out_valid;
    logic                 out_stall    = 1'b0;
    logic [DATA_W-1:0]    read_value;
    logic                 error;
    logic                 cfg_write    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [CFG_W-1:0]     cfg_data     = '0;

    matrix_scoreboard sb;

    // calm: no idling on either side; hold_req: receiver starts a long hold-off
    bit calm     = 1'b0;
    bit hold_req = 1'b0;

    byte_matrix_flip_transpose #(
        .MAX_DIM (DIM)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .row          (row),
        .col          (col),
        .cell_value   (cell_value),
        .first_index  (first_index),
        .second_index (second_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .read_value   (read_value),
        .error        (error),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop, far beyond the slowest legal run of whole-matrix walks and stalls.
    initial
    begin
        #10_000_000;
        $display("FAIL byte_matrix_flip_transpose");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Receiver: samples right after the edge, so it sees the values that
    // took part in the handshake. Random stall about 19% of cycles, none
    // while calm, and a counted hold-off on request.
    // ---------------------------------------------------------------------
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_result(read_value, error);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !calm && ($urandom_range(0, 99) < 19);
        end
    end

    // ---------------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------------

    // Offer one beat, after a random gap, and wait for it to be taken.
    // in_valid is only lowered when a gap follows, so a back-to-back beat
    // never sees two assignments to it in one step.
    task automatic send_beat(beat_t b);
        int gap;
        gap = 0;
        while (!calm && $urandom_range(0, 99) < 19)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        opcode       <= b.opcode;
        row          <= b.row;
        col          <= b.col;
        cell_value   <= b.cell_value;
        first_index  <= b.first_index;
        second_index <= b.second_index;
        in_valid     <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(b);
    endtask

    // Unused fields get random bits so every input bit toggles.
    function automatic beat_t noise_beat();
        beat_t b;
        b.opcode       = 3'($urandom);
        b.row          = 6'($urandom);
        b.col          = 6'($urandom);
        b.cell_value   = 8'($urandom);
        b.first_index  = 6'($urandom);
        b.second_index = 6'($urandom);
        return b;
    endfunction

    task automatic send_op(logic [OPCODE_W-1:0] op, int r, int c, int v, int fa, int sa);
        beat_t b;
        b              = noise_beat();
        b.opcode       = op;
        b.row          = 6'(r);
        b.col          = 6'(c);
        b.cell_value   = 8'(v);
        b.first_index  = 6'(fa);
        b.second_index = 6'(sa);
        send_beat(b);
    endtask

    // Random beat: mostly in-range cell and swap traffic, some whole-matrix
    // ops, some out-of-range and unused-opcode noise. A read that would land
    // on a never-written cell is turned into a write of that cell.
    function automatic beat_t random_beat();
        beat_t b;
        int    pick;
        int    nr;
        int    nc;
        int    lim;
        nr   = sb.active_rows();
        nc   = sb.active_cols();
        b    = noise_beat();
        pick = $urandom_range(0, 99);
        if (pick < 30)
            b.opcode = OP_WRITE;
        else if (pick < 60)
            b.opcode = OP_READ;
        else if (pick < 67)
            b.opcode = OP_FLIP_VERT;
        else if (pick < 74)
            b.opcode = OP_FLIP_HORIZ;
        else if (pick < 82)
            b.opcode = OP_TRANSPOSE;
        else if (pick < 90)
            b.opcode = OP_SWAP_ROWS;
        else if (pick < 97)
            b.opcode = OP_SWAP_COLS;
        else
            b.opcode = OP_UNUSED;

        if ((b.opcode == OP_WRITE || b.opcode == OP_READ) && nr > 0 && nc > 0
            && $urandom_range(0, 9) < 8)
        begin
            b.row = 6'($urandom_range(0, nr - 1));
            b.col = 6'($urandom_range(0, nc - 1));
        end

        lim = (b.opcode == OP_SWAP_ROWS) ? nr : nc;
        if ((b.opcode == OP_SWAP_ROWS || b.opcode == OP_SWAP_COLS) && lim > 0
            && $urandom_range(0, 99) < 85)
        begin
            b.first_index  = 6'($urandom_range(0, lim - 1));
            b.second_index = ($urandom_range(0, 9) == 0) ? b.first_index
                                                         : 6'($urandom_range(0, lim - 1));
        end

        if (b.opcode == OP_READ && int'(b.row) < nr && int'(b.col) < nc
            && !sb.is_written(b.row, b.col))
            b.opcode = OP_WRITE;
        return b;
    endfunction

    task automatic run_random(int n);
        repeat (n) send_beat(random_beat());
    endtask

    // Stop offering, wait until every expected result is back, then let the
    // block settle so the next config write lands on an idle block.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (8) @(posedge clk);
    endtask

    // Both count registers, on back-to-back edges; cfg_write stays high.
    task automatic set_dims(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols);
        cfg_write <= 1'b1;
        cfg_index <= REG_ROW_COUNT;
        cfg_data  <= rows;
        @(posedge clk);
        sb.set_count(REG_ROW_COUNT, rows);
        cfg_index <= REG_COLUMN_COUNT;
        cfg_data  <= cols;
        @(posedge clk);
        sb.set_count(REG_COLUMN_COUNT, cols);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial
    begin
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed, at the reset size 64x64 ---
        send_op(OP_WRITE, 0, 0, 8'hFF, 0, 0);
        send_op(OP_WRITE, 63, 63, 8'h00, 0, 0);
        send_op(OP_WRITE, 0, 63, 8'hA5, 0, 0);
        send_op(OP_WRITE, 63, 0, 8'h5A, 0, 0);
        send_op(OP_READ, 0, 0, 0, 0, 0);
        send_op(OP_READ, 63, 63, 0, 0, 0);
        send_op(OP_FLIP_VERT, 0, 0, 0, 0, 0);
        send_op(OP_READ, 0, 0, 0, 0, 0);          // column 63 moved to 0
        send_op(OP_FLIP_HORIZ, 0, 0, 0, 0, 0);
        send_op(OP_TRANSPOSE, 0, 0, 0, 0, 0);
        send_op(OP_SWAP_ROWS, 0, 0, 0, 0, 63);
        send_op(OP_SWAP_COLS, 0, 0, 0, 63, 0);
        send_op(OP_SWAP_ROWS, 0, 0, 0, 5, 5);     // row with itself
        send_op(OP_UNUSED, 0, 0, 0, 0, 0);
        drain_results();

        // non-square 3x5: range errors, transpose refused
        set_dims(7'd3, 7'd5);
        send_op(OP_WRITE, 2, 4, 8'h3C, 0, 0);
        send_op(OP_WRITE, 3, 0, 8'h11, 0, 0);     // row out of range
        send_op(OP_READ, 0, 5, 0, 0, 0);          // column out of range
        send_op(OP_TRANSPOSE, 0, 0, 0, 0, 0);
        send_op(OP_SWAP_ROWS, 0, 0, 0, 0, 3);     // second row out of range
        send_op(OP_SWAP_COLS, 0, 0, 0, 1, 4);
        drain_results();

        // 1x1: transpose is a no-op success
        set_dims(7'd1, 7'd1);
        send_op(OP_WRITE, 0, 0, 8'h77, 0, 0);
        send_op(OP_TRANSPOSE, 0, 0, 0, 0, 0);
        send_op(OP_READ, 0, 0, 0, 0, 0);
        drain_results();

        // empty matrix: flips and transpose leave it alone, cells refused
        set_dims(7'd0, 7'd0);
        send_op(OP_FLIP_VERT, 0, 0, 0, 0, 0);
        send_op(OP_FLIP_HORIZ, 0, 0, 0, 0, 0);
        send_op(OP_TRANSPOSE, 0, 0, 0, 0, 0);
        send_op(OP_WRITE, 0, 0, 8'h01, 0, 0);
        drain_results();

        // counts above the limit saturate to 64
        set_dims(7'd127, 7'd100);
        send_op(OP_WRITE, 63, 10, 8'hC3, 0, 0);
        send_op(OP_READ, 63, 10, 0, 0, 0);
        drain_results();

        // --- random phases, mostly small sizes ---
        set_dims(7'd4, 7'd4);
        run_random(20);
        drain_results();

        set_dims(7'd2, 7'd7);
        run_random(15);
        drain_results();

        // stretch with no idling on either side
        calm = 1'b1;
        set_dims(7'd8, 7'd8);
        run_random(20);
        drain_results();
        calm = 1'b0;

        set_dims(7'd1, 7'd64);
        run_random(10);
        drain_results();

        set_dims(7'd64, 7'd64);
        run_random(12);
        drain_results();

        // sender pauses midway until everything is back
        set_dims(7'd5, 7'd3);
        run_random(10);
        drain_results();
        run_random(10);
        drain_results();

        // receiver holds off while beats keep coming: block fills, input stalls
        set_dims(7'd6, 7'd6);
        hold_req = 1'b1;
        run_random(15);
        drain_results();

        if (sb.errors == 0)
            $display("PASS byte_matrix_flip_transpose");
        else
            $display("FAIL byte_matrix_flip_transpose");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
+incdir+rtl
rtl/bmft_pkg.sv
rtl/bmft_walk.sv
rtl/byte_matrix_flip_transpose.sv
rtl/bmft_checker.sv
sim/tb_byte_matrix_flip_transpose.sv
